[rtl/core/plc_pkg.sv]
package plc_pkg;

  localparam int unsigned COORD_BITS      = 13;
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned IMAGE_BYTES_DEF = 65536;
  localparam int unsigned QDEPTH          = 4;

  localparam logic [7:0] TRANSPARENT = 8'hFF;

  localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_UI_ORIGIN    = 3'd2;
  localparam logic [2:0] CFG_UI_EXTENT    = 3'd3;
  localparam logic [2:0] CFG_BAR_ORIGIN   = 3'd4;
  localparam logic [2:0] CFG_BAR_EXTENT   = 3'd5;
  localparam logic [2:0] CFG_ENABLES      = 3'd6;

  typedef enum logic [2:0] {
    OP_COMPOSE  = 3'd0,
    OP_WR_BASE  = 3'd1,
    OP_WR_OVL   = 3'd2,
    OP_WR_TOP   = 3'd3,
    OP_WR_BAR   = 3'd4,
    OP_WR_UI    = 3'd5
  } op_e;

  typedef struct packed {
    logic [12:0] frame_width;
    logic [12:0] frame_height;
    logic [25:0] ui_origin;
    logic [25:0] ui_extent;
    logic [25:0] bar_origin;
    logic [25:0] bar_extent;
    logic [2:0]  enables;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic        bar_hit;
    logic        ui_hit;
    logic        top_on;
    logic [7:0]  base_index;
    logic [7:0]  upper_index;
    logic [15:0] waddr;
    logic [31:0] wdata;
  } item_t;

  typedef struct packed {
    item_t             itm;
    logic [3:0][25:0]  dvd;
  } qent_t;

  typedef struct packed {
    logic [12:0] rem;
    logic [12:0] low;
  } div_t;

  function automatic div_t div_step(div_t s, logic [12:0] dv);
    logic [13:0] t;
    div_t        r;
    t     = {s.rem, s.low[12]};
    r.low = {s.low[11:0], 1'b0};
    if (t >= {1'b0, dv}) begin
      t        = t - {1'b0, dv};
      r.low[0] = 1'b1;
    end
    r.rem = t[12:0];
    return r;
  endfunction

endpackage

[rtl/core/palette_layer_compositor.sv]
// Indexed-color compositor: each compose item yields one XRGB pixel (none when the
// pixel lies outside the frame), write items load the three palettes and the two
// overlay images and yield nothing. The block takes one item per clock when the
// output is not stalled; an accepted item passes through the front register and
// the queue, then the 13-step pipelined dividers that scale each overlay
// coordinate, followed by the address multiply, the image read and the palette
// read. Palettes and images have no reset contents and need no clearing pass;
// IMAGE_BYTES is a power of two. Write configuration only while the block is idle.
module palette_layer_compositor #(
  parameter int unsigned IMAGE_BYTES = plc_pkg::IMAGE_BYTES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [25:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic [7:0]  base_index_i,
  input  logic [7:0]  upper_index_i,
  input  logic [15:0] write_address_i,
  input  logic [31:0] write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] pixel_color_o
);
  import plc_pkg::*;

  cfg_t  cfg_q;
  logic  push, q_full, q_valid, q_pop;
  qent_t push_data, q_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_width  <= 13'd320;
      cfg_q.frame_height <= 13'd200;
      cfg_q.ui_origin    <= '0;
      cfg_q.ui_extent    <= '0;
      cfg_q.bar_origin   <= '0;
      cfg_q.bar_extent   <= '0;
      cfg_q.enables      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_FRAME_WIDTH:  cfg_q.frame_width  <= cfg_data_i[12:0];
        CFG_FRAME_HEIGHT: cfg_q.frame_height <= cfg_data_i[12:0];
        CFG_UI_ORIGIN:    cfg_q.ui_origin    <= cfg_data_i;
        CFG_UI_EXTENT:    cfg_q.ui_extent    <= cfg_data_i;
        CFG_BAR_ORIGIN:   cfg_q.bar_origin   <= cfg_data_i;
        CFG_BAR_EXTENT:   cfg_q.bar_extent   <= cfg_data_i;
        CFG_ENABLES:      cfg_q.enables      <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  plc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .func_i          (func_i),
    .pixel_x_i       (pixel_x_i),
    .pixel_y_i       (pixel_y_i),
    .base_index_i    (base_index_i),
    .upper_index_i   (upper_index_i),
    .write_address_i (write_address_i),
    .write_data_i    (write_data_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  plc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_data),
    .pop_i   (q_pop)
  );

  plc_back #(
    .IMAGE_BYTES (IMAGE_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_data_i      (q_data),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o)
  );

endmodule

[rtl/core/plc_front.sv]
module plc_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plc_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [2:0]     func_i,
  input  logic [11:0]    pixel_x_i,
  input  logic [11:0]    pixel_y_i,
  input  logic [7:0]     base_index_i,
  input  logic [7:0]     upper_index_i,
  input  logic [15:0]    write_address_i,
  input  logic [31:0]    write_data_i,
  input  logic           q_full_i,
  output logic           push_o,
  output plc_pkg::qent_t push_data_o
);
  import plc_pkg::*;

  logic        f_vld_q, f_vld_d;
  qent_t       f_q, ent;
  logic        keep, accept, in_frame;
  logic        bar_in, ui_in;
  logic [13:0] bar_bx, bar_by, ui_bx, ui_by;

  assign in_stall_o = f_vld_q && q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = f_vld_q && !q_full_i;
  assign push_data_o = f_q;

  assign in_frame = ({1'b0, pixel_x_i} < cfg_i.frame_width) &&
                    ({1'b0, pixel_y_i} < cfg_i.frame_height);

  assign bar_bx = {2'b00, pixel_x_i} - {cfg_i.bar_origin[12], cfg_i.bar_origin[12:0]};
  assign bar_by = {2'b00, pixel_y_i} - {cfg_i.bar_origin[25], cfg_i.bar_origin[25:13]};
  assign ui_bx  = {2'b00, pixel_x_i} - {cfg_i.ui_origin[12], cfg_i.ui_origin[12:0]};
  assign ui_by  = {2'b00, pixel_y_i} - {cfg_i.ui_origin[25], cfg_i.ui_origin[25:13]};

  assign bar_in = !bar_bx[13] && !bar_by[13] &&
                  (bar_bx[12:0] < cfg_i.bar_extent[12:0]) &&
                  (bar_by[12:0] < cfg_i.bar_extent[25:13]);
  assign ui_in  = !ui_bx[13] && !ui_by[13] &&
                  (ui_bx[12:0] < cfg_i.ui_extent[12:0]) &&
                  (ui_by[12:0] < cfg_i.ui_extent[25:13]);

  always_comb begin
    keep = 1'b0;
    unique case (func_i) inside
      OP_COMPOSE: begin
        keep = in_frame;
      end
      OP_WR_BASE, OP_WR_OVL, OP_WR_TOP, OP_WR_BAR, OP_WR_UI: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_comb begin
    ent.itm.op          = op_e'(func_i);
    ent.itm.bar_hit     = cfg_i.enables[0] && bar_in;
    ent.itm.ui_hit      = cfg_i.enables[1] && ui_in;
    ent.itm.top_on      = cfg_i.enables[2] && (upper_index_i != TRANSPARENT);
    ent.itm.base_index  = base_index_i;
    ent.itm.upper_index = upper_index_i;
    ent.itm.waddr       = write_address_i;
    ent.itm.wdata       = write_data_i;
    ent.dvd[0]          = {13'b0, bar_bx[12:0]} * {13'b0, cfg_i.frame_width};
    ent.dvd[1]          = {13'b0, bar_by[12:0]} * {13'b0, cfg_i.frame_height};
    ent.dvd[2]          = {13'b0, ui_bx[12:0]} * {13'b0, cfg_i.frame_width};
    ent.dvd[3]          = {13'b0, ui_by[12:0]} * {13'b0, cfg_i.frame_height};
  end

  always_comb begin
    f_vld_d = f_vld_q;
    if (accept) begin
      f_vld_d = keep;
    end else if (push_o) begin
      f_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else begin
      f_vld_q <= f_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_q <= ent;
    end
  end

endmodule

[rtl/core/plc_queue.sv]
module plc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  plc_pkg::qent_t data_i,
  output logic           full_o,
  output logic           valid_o,
  output plc_pkg::qent_t data_o,
  input  logic           pop_i
);
  import plc_pkg::*;

  localparam int unsigned PtrW = $clog2(QDEPTH);

  qent_t               mem_q [QDEPTH];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  assign full_o  = (cnt_q == (PtrW+1)'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[rtl/core/plc_back.sv]
module plc_back #(
  parameter int unsigned IMAGE_BYTES = plc_pkg::IMAGE_BYTES_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  plc_pkg::cfg_t  cfg_i,
  input  logic           q_valid_i,
  input  plc_pkg::qent_t q_data_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic [31:0]    pixel_color_o
);
  import plc_pkg::*;

  localparam int unsigned ImageAw = $clog2(IMAGE_BYTES);
  localparam int unsigned Steps   = COORD_BITS;
  localparam int unsigned Last    = Steps - 1;

  logic                  adv;
  logic [12:0]           dv [4];

  logic [Steps-1:0]      sv_q;
  item_t                 itm_q [Steps];
  div_t                  dq_q  [Steps][4];

  logic [26:0]           bar_lin, ui_lin;
  logic                  a_vld_q;
  item_t                 a_itm_q;
  logic [ImageAw-1:0]    a_bar_q, a_ui_q;

  logic [7:0]            bar_img [IMAGE_BYTES];
  logic [7:0]            ui_img  [IMAGE_BYTES];
  logic [ImageAw-1:0]    img_wa;
  logic                  m_vld_q;
  item_t                 m_itm_q;
  logic [7:0]            bar_pix_q, ui_pix_q;

  logic [31:0]           base_pal [PALETTE_ENTRIES];
  logic [31:0]           ovl_pal  [PALETTE_ENTRIES];
  logic [31:0]           top_pal  [PALETTE_ENTRIES];
  logic                  ui_use, bar_use;
  logic [7:0]            ovl_sel;
  logic                  p_vld_q, p_use_ovl_q, p_use_top_q;
  logic [31:0]           base_rd_q, ovl_rd_q, top_rd_q;

  logic                  out_vld_q;
  logic [31:0]           pixel_q;

  assign adv           = !(out_vld_q && out_stall_i);
  assign q_pop_o       = adv && q_valid_i;
  assign out_valid_o   = out_vld_q;
  assign pixel_color_o = pixel_q;

  assign dv[0] = cfg_i.bar_extent[12:0];
  assign dv[1] = cfg_i.bar_extent[25:13];
  assign dv[2] = cfg_i.ui_extent[12:0];
  assign dv[3] = cfg_i.ui_extent[25:13];

  assign bar_lin = ({14'b0, dq_q[Last][1].low} * {14'b0, cfg_i.frame_width}) +
                   {14'b0, dq_q[Last][0].low};
  assign ui_lin  = ({14'b0, dq_q[Last][3].low} * {14'b0, cfg_i.frame_width}) +
                   {14'b0, dq_q[Last][2].low};
  assign img_wa  = ImageAw'(a_itm_q.waddr);

  assign ui_use  = m_itm_q.ui_hit && (ui_pix_q != TRANSPARENT);
  assign bar_use = m_itm_q.bar_hit && (bar_pix_q != TRANSPARENT);
  assign ovl_sel = ui_use ? ui_pix_q : bar_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q      <= '0;
      a_vld_q   <= 1'b0;
      m_vld_q   <= 1'b0;
      p_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      sv_q      <= {sv_q[Steps-2:0], q_pop_o};
      a_vld_q   <= sv_q[Last];
      m_vld_q   <= a_vld_q;
      p_vld_q   <= m_vld_q && (m_itm_q.op == OP_COMPOSE);
      out_vld_q <= p_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      itm_q[0] <= q_data_i.itm;
      for (int d = 0; d < 4; d++) begin
        dq_q[0][d] <= div_step('{rem: q_data_i.dvd[d][25:13], low: q_data_i.dvd[d][12:0]},
                               dv[d]);
      end
      for (int s = 1; s < Steps; s++) begin
        itm_q[s] <= itm_q[s-1];
        for (int d = 0; d < 4; d++) begin
          dq_q[s][d] <= div_step(dq_q[s-1][d], dv[d]);
        end
      end
      a_itm_q <= itm_q[Last];
      a_bar_q <= ImageAw'(bar_lin);
      a_ui_q  <= ImageAw'(ui_lin);
      m_itm_q <= a_itm_q;
      p_use_ovl_q <= ui_use || bar_use;
      p_use_top_q <= m_itm_q.top_on;
      pixel_q <= p_use_top_q ? top_rd_q : (p_use_ovl_q ? ovl_rd_q : base_rd_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (a_vld_q && (a_itm_q.op == OP_WR_BAR)) begin
        bar_img[img_wa] <= a_itm_q.wdata[7:0];
      end
      if (a_vld_q && (a_itm_q.op == OP_WR_UI)) begin
        ui_img[img_wa] <= a_itm_q.wdata[7:0];
      end
      bar_pix_q <= bar_img[a_bar_q];
      ui_pix_q  <= ui_img[a_ui_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (m_vld_q && (m_itm_q.op == OP_WR_BASE)) begin
        base_pal[m_itm_q.waddr[7:0]] <= m_itm_q.wdata;
      end
      if (m_vld_q && (m_itm_q.op == OP_WR_OVL)) begin
        ovl_pal[m_itm_q.waddr[7:0]] <= m_itm_q.wdata;
      end
      if (m_vld_q && (m_itm_q.op == OP_WR_TOP)) begin
        top_pal[m_itm_q.waddr[7:0]] <= m_itm_q.wdata;
      end
      base_rd_q <= base_pal[m_itm_q.base_index];
      ovl_rd_q  <= ovl_pal[ovl_sel];
      top_rd_q  <= top_pal[m_itm_q.upper_index];
    end
  end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import plc_pkg::*;

  localparam int unsigned IMG = IMAGE_BYTES_DEF;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned DRAIN_CYCLES = 60;

  class color_predictor;
    logic [12:0] fw, fh;
    logic [25:0] ui_org, ui_ext, bar_org, bar_ext;
    logic [2:0]  en;
    logic [31:0] base_pal[PALETTE_ENTRIES];
    logic [31:0] ovl_pal[PALETTE_ENTRIES];
    logic [31:0] top_pal[PALETTE_ENTRIES];
    logic [7:0]  bar_img[IMG];
    logic [7:0]  ui_img[IMG];
    bit          base_ok[PALETTE_ENTRIES];
    bit          ovl_ok[PALETTE_ENTRIES];
    bit          top_ok[PALETTE_ENTRIES];
    bit          bar_ok[IMG];
    bit          ui_ok[IMG];
    logic [31:0] pending_colors[$];
    int          errors;

    function new();
      fw = 13'd320;
      fh = 13'd200;
      ui_org = '0;
      ui_ext = '0;
      bar_org = '0;
      bar_ext = '0;
      en = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [25:0] data);
      case (idx)
        CFG_FRAME_WIDTH:  fw = data[12:0];
        CFG_FRAME_HEIGHT: fh = data[12:0];
        CFG_UI_ORIGIN:    ui_org = data;
        CFG_UI_EXTENT:    ui_ext = data;
        CFG_BAR_ORIGIN:   bar_org = data;
        CFG_BAR_EXTENT:   bar_ext = data;
        CFG_ENABLES:      en = data[2:0];
        default: ;
      endcase
    endfunction

    function bit locate(bit is_ui, logic [11:0] px, logic [11:0] py, output longint addr);
      logic [25:0] org, ext;
      longint      ox, oy, bx, by, w, h, sx, sy;
      org = is_ui ? ui_org : bar_org;
      ext = is_ui ? ui_ext : bar_ext;
      ox = $signed(org[12:0]);
      oy = $signed(org[25:13]);
      bx = longint'(px) - ox;
      by = longint'(py) - oy;
      w = ext[12:0];
      h = ext[25:13];
      addr = 0;
      if (bx < 0 || by < 0 || bx >= w || by >= h) return 0;
      sx = (bx * longint'(fw)) / w;
      sy = (by * longint'(fh)) / h;
      addr = (sy * longint'(fw) + sx) % IMG;
      return 1;
    endfunction

    function void note_item(logic [2:0] func, logic [11:0] px, logic [11:0] py,
                            logic [7:0] bidx, logic [7:0] tidx,
                            logic [15:0] waddr, logic [31:0] wdata);
      logic [31:0] color;
      longint      addr;
      case (func)
        OP_WR_BASE: begin
          base_pal[waddr[7:0]] = wdata;
          base_ok[waddr[7:0]] = 1;
        end
        OP_WR_OVL: begin
          ovl_pal[waddr[7:0]] = wdata;
          ovl_ok[waddr[7:0]] = 1;
        end
        OP_WR_TOP: begin
          top_pal[waddr[7:0]] = wdata;
          top_ok[waddr[7:0]] = 1;
        end
        OP_WR_BAR: begin
          bar_img[waddr % IMG] = wdata[7:0];
          bar_ok[waddr % IMG] = 1;
        end
        OP_WR_UI: begin
          ui_img[waddr % IMG] = wdata[7:0];
          ui_ok[waddr % IMG] = 1;
        end
        OP_COMPOSE: begin
          if (px < fw && py < fh) begin
            color = base_pal[bidx];
            if (en[0] && locate(0, px, py, addr) && bar_img[addr] != TRANSPARENT)
              color = ovl_pal[bar_img[addr]];
            if (en[1] && locate(1, px, py, addr) && ui_img[addr] != TRANSPARENT)
              color = ovl_pal[ui_img[addr]];
            if (en[2] && tidx != TRANSPARENT) color = top_pal[tidx];
            pending_colors.push_back(color);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_color(logic [31:0] got);
      logic [31:0] want;
      if (pending_colors.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected item: pixel_color=%h", got);
        return;
      end
      want = pending_colors.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("pixel_color mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [25:0] cfg_data_i;
  logic        in_valid_i, in_stall_o;
  logic [2:0]  func_i;
  logic [11:0] pixel_x_i, pixel_y_i;
  logic [7:0]  base_index_i, upper_index_i;
  logic [15:0] write_address_i;
  logic [31:0] write_data_i;
  logic        out_valid_o, out_stall_i;
  logic [31:0] pixel_color_o;

  color_predictor colors;
  int unsigned    cycles;
  int             stall_left;
  bit             hold;
  bit             rand_phase;
  bit             quiet;

  palette_layer_compositor i_dut (.*);

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  initial begin
    colors = new();
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i <= '0;
    in_valid_i <= 1'b0;
    func_i <= '0;
    pixel_x_i <= '0;
    pixel_y_i <= '0;
    base_index_i <= '0;
    upper_index_i <= '0;
    write_address_i <= '0;
    write_data_i <= '0;
    out_stall_i <= 1'b0;
    hold = 0;
    rand_phase = 0;
    quiet = 1;
    stall_left = 0;
    cycles = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 70);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) colors.check_color(pixel_color_o);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (!quiet && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
    end
    out_stall_i <= hold || (stall_left > 0);
  end

  initial begin
    wait (rand_phase);
    repeat (150) @(posedge clk_i);
    hold = 1;
    repeat (400) @(posedge clk_i);
    hold = 0;
  end

  task automatic send(logic [2:0] func, logic [11:0] px, logic [11:0] py, logic [7:0] bidx,
                      logic [7:0] tidx, logic [15:0] waddr, logic [31:0] wdata);
    int gap;
    in_valid_i <= 1'b1;
    func_i <= func;
    pixel_x_i <= px;
    pixel_y_i <= py;
    base_index_i <= bidx;
    upper_index_i <= tidx;
    write_address_i <= waddr;
    write_data_i <= wdata;
    do @(posedge clk_i); while (in_stall_o);
    colors.note_item(func, px, py, bidx, tidx, waddr, wdata);
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic logic [7:0] rand_index();
    if ($urandom_range(0, 3) == 0) return TRANSPARENT;
    return 8'($urandom_range(0, 31));
  endfunction

  task automatic fill_for(logic [11:0] px, logic [11:0] py, logic [7:0] bidx,
                          logic [7:0] tidx);
    longint     addr;
    logic [7:0] idx;
    bit         hit;
    if (px >= colors.fw || py >= colors.fh) return;
    if (!colors.base_ok[bidx]) send(OP_WR_BASE, '0, '0, '0, '0, 16'(bidx), $urandom);
    for (int l = 0; l < 2; l++) begin
      hit = colors.en[l] && colors.locate(l == 1, px, py, addr);
      if (hit) begin
        if ((l == 1) ? !colors.ui_ok[addr] : !colors.bar_ok[addr]) begin
          send((l == 1) ? OP_WR_UI : OP_WR_BAR, '0, '0, '0, '0, 16'(addr),
               {24'($urandom), rand_index()});
        end
        idx = (l == 1) ? colors.ui_img[addr] : colors.bar_img[addr];
        if (idx != TRANSPARENT && !colors.ovl_ok[idx]) begin
          send(OP_WR_OVL, '0, '0, '0, '0, 16'(idx), $urandom);
        end
      end
    end
    if (colors.en[2] && tidx != TRANSPARENT && !colors.top_ok[tidx]) begin
      send(OP_WR_TOP, '0, '0, '0, '0, 16'(tidx), $urandom);
    end
  endtask

  task automatic compose(logic [11:0] px, logic [11:0] py, logic [7:0] bidx,
                         logic [7:0] tidx);
    fill_for(px, py, bidx, tidx);
    send(OP_COMPOSE, px, py, bidx, tidx, '0, '0);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (colors.pending_colors.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [25:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    colors.set_reg(idx, data);
  endtask

  function automatic logic [12:0] rand_coord(logic [12:0] span);
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 13'($urandom);
    if (r == 1) return -13'($urandom_range(0, span));
    return 13'($urandom_range(0, span));
  endfunction

  function automatic logic [12:0] rand_size(logic [12:0] span);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return 13'h1FFF;
    if (r == 2) return 13'($urandom);
    return 13'($urandom_range(1, span + 1));
  endfunction

  task automatic setup_frame(logic [12:0] fw, logic [12:0] fh, logic [2:0] en);
    write_reg(CFG_FRAME_WIDTH, 26'(fw));
    write_reg(CFG_FRAME_HEIGHT, 26'(fh));
    write_reg(CFG_BAR_ORIGIN, {rand_coord(fh), rand_coord(fw)});
    write_reg(CFG_BAR_EXTENT, {rand_size(fh), rand_size(fw)});
    write_reg(CFG_UI_ORIGIN, {rand_coord(fh), rand_coord(fw)});
    write_reg(CFG_UI_EXTENT, {rand_size(fh), rand_size(fw)});
    write_reg(CFG_ENABLES, 26'(en));
  endtask

  function automatic logic [11:0] rand_pos(logic [12:0] lim);
    if (lim == 0 || $urandom_range(0, 9) == 0) return 12'($urandom);
    return 12'($urandom_range(0, (lim > 4096 ? 4096 : lim) - 1));
  endfunction

  task automatic rand_item();
    int          r;
    logic [7:0]  tidx;
    r = $urandom_range(0, 99);
    tidx = rand_index();
    if (r < 72) begin
      compose(rand_pos(colors.fw), rand_pos(colors.fh), rand_index(), tidx);
    end else if (r < 96) begin
      send(3'($urandom_range(OP_WR_BASE, OP_WR_UI)), rand_pos(colors.fw),
           rand_pos(colors.fh), 8'($urandom), tidx, 16'($urandom), $urandom);
    end else begin
      send(3'($urandom_range(6, 7)), rand_pos(colors.fw), rand_pos(colors.fh),
           8'($urandom), tidx, 16'($urandom), $urandom);
    end
  endtask

  initial begin
    int          n;
    logic [12:0] fw, fh;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_ENABLES, '0);
    quiet = 0;
    settle();

    write_reg(CFG_FRAME_WIDTH, 26'd320);
    write_reg(CFG_FRAME_HEIGHT, 26'd200);
    write_reg(CFG_BAR_ORIGIN, '0);
    write_reg(CFG_BAR_EXTENT, {13'd20, 13'd320});
    write_reg(CFG_UI_ORIGIN, {-13'sd10, -13'sd10});
    write_reg(CFG_UI_EXTENT, {13'd100, 13'd100});
    write_reg(CFG_ENABLES, 26'd7);
    compose(12'd0, 12'd0, 8'd0, TRANSPARENT);
    compose(12'd319, 12'd199, 8'd255, TRANSPARENT);
    compose(12'd50, 12'd10, 8'd255, 8'd0);
    compose(12'd89, 12'd89, 8'd1, 8'd254);
    compose(12'd320, 12'd0, 8'd2, 8'd3);
    compose(12'd0, 12'd200, 8'd2, 8'd3);
    compose(12'hFFF, 12'hFFF, 8'd4, 8'd5);
    send(3'd6, 12'd1, 12'd1, 8'd1, 8'd1, 16'hFFFF, '1);
    send(3'd7, 12'd1, 12'd1, 8'd1, 8'd1, 16'hFFFF, '1);
    send(OP_WR_BASE, '0, '0, '0, '0, 16'hFFFF, 32'hFFFFFFFF);
    send(OP_WR_OVL, '0, '0, '0, '0, 16'hFF00, 32'h00000000);
    send(OP_WR_TOP, '0, '0, '0, '0, 16'h01FF, 32'hA5A5A5A5);
    send(OP_WR_BAR, '0, '0, '0, '0, 16'hFFFF, 32'hFFFFFF00);
    send(OP_WR_UI, '0, '0, '0, '0, 16'h0000, 32'h000000FF);
    compose(12'd5, 12'd5, 8'd255, 8'd255);
    compose(12'd200, 12'd150, 8'd0, 8'd255);
    settle();

    write_reg(CFG_FRAME_WIDTH, 26'd0);
    compose(12'd0, 12'd0, 8'd0, 8'd0);
    settle();

    write_reg(CFG_FRAME_WIDTH, 26'd4096);
    write_reg(CFG_FRAME_HEIGHT, 26'd4096);
    write_reg(CFG_BAR_ORIGIN, {13'h1000, 13'h1000});
    write_reg(CFG_BAR_EXTENT, {13'h1FFF, 13'h1FFF});
    write_reg(CFG_UI_ORIGIN, {13'h0FFF, 13'h0000});
    write_reg(CFG_UI_EXTENT, {13'd4096, 13'd4096});
    write_reg(CFG_ENABLES, 26'd3);
    for (n = 0; n < 40; n++) rand_item();
    settle();

    setup_frame(13'd1, 13'd1, 3'd7);
    for (n = 0; n < 30; n++) rand_item();
    settle();

    rand_phase = 1;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 3)
        0: begin fw = 13'($urandom_range(1, 64)); fh = 13'($urandom_range(1, 64)); end
        1: begin fw = 13'($urandom_range(1, 400)); fh = 13'($urandom_range(1, 300)); end
        default: begin fw = 13'($urandom_range(1, 4096)); fh = 13'($urandom_range(1, 4096)); end
      endcase
      setup_frame(fw, fh, 3'($urandom));
      for (n = 0; n < 70; n++) rand_item();
      settle();
    end

    if (colors.errors == 0 && colors.pending_colors.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
